/* hdl/hpq_pkg.sv */
// Shared types and constants for the binary max-heap priority queue.
`default_nettype none

package hpq_pkg;

    localparam int OP_W     = 2;
    localparam int KEYIO_W  = 32;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_REMOVE  = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BAD_SLOT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAKE,
        S_LAST,
        S_RM_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* hdl/hpq_if.sv */
// Request and response channel interfaces of the heap priority queue.
`default_nettype none

interface hpq_req_if import hpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [KEYIO_W-1:0]  key_in;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, opcode, key_in, slot, input ready);
    modport sink   (input valid, opcode, key_in, slot, output ready);
endinterface

interface hpq_rsp_if import hpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KEYIO_W-1:0]  key_out;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, key_out, status, occupancy, input ready);
    modport sink   (input valid, key_out, status, occupancy, output ready);
endinterface

`default_nettype wire

/* hdl/hpq_mem.sv */
// Heap key store: one write port and one registered read port.
`default_nettype none

module hpq_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/binary_max_heap_queue.sv */
// Binary max-heap priority queue: sequencer, heap store and response register.
//
// Requests arrive on req (opcode, key_in, slot) and each one returns exactly
// one response on rsp (key_out, status, occupancy). Push inserts key_in,
// extract removes the maximum, remove takes out the entry at heap array index
// slot. Status reports ok, full (push dropped), empty, or a slot not below the
// current count; in those error cases the heap is untouched and key_out is zero.
//
// One request is worked on at a time; req.ready is high only while the
// sequencer is idle. Each sift level costs a read of the registered memory
// and a compare; a remove below the root adds a parent compare. Once a
// response is loaded the sequencer returns to idle and accepts the next one.
//
// A waiting response sits in the output register; the next request is still
// accepted and processed and only the loading of its response waits for
// rsp.ready. Reset clears the count and handshake state, not the memory.
`default_nettype none

module binary_max_heap_queue import hpq_pkg::*; #(
    parameter int DEPTH = 128,
    parameter int KEY_W = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hpq_req_if.sink   req,
    hpq_rsp_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;
    localparam int XW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

    // Sequencer state.
    state_t             state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;     // current hole position
    logic [AW-1:0]      tgt_reg, tgt_next;     // slot being emptied
    logic [CW-1:0]      cnt_reg, cnt_next;     // entries held
    logic [KEY_W-1:0]   key_reg, key_next;     // key being sifted
    logic [KEY_W-1:0]   lkey_reg, lkey_next;   // left child during sift-down
    logic [KEY_W-1:0]   kout_reg, kout_next;   // key handed back
    status_t            stat_reg, stat_next;

    // Response register.
    logic               rsp_valid_reg, rsp_valid_next;
    logic [KEYIO_W-1:0] rsp_key_reg, rsp_key_next;
    status_t            rsp_status_reg, rsp_status_next;
    logic [OCC_W-1:0]   rsp_occ_reg, rsp_occ_next;

    // Memory ports.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [KEY_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [KEY_W-1:0]   mem_rdata;

    // Index arithmetic.
    logic [AW-1:0]      par_idx;
    logic [AW-1:0]      tgt_par;
    logic [IW-1:0]      lft_w;
    logic [IW-1:0]      rgt_w;
    logic [IW-1:0]      cnt_w;
    logic               has_left;
    logic               has_right;
    logic               pick_left;
    logic [KEY_W-1:0]   max_key;
    logic [AW-1:0]      max_idx;
    logic               rsp_load;

    hpq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (KEY_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign par_idx   = AW'((idx_reg - AW'(1)) >> 1);
    assign tgt_par   = AW'((tgt_reg - AW'(1)) >> 1);
    assign lft_w     = (IW'(idx_reg) << 1) + IW'(1);
    assign rgt_w     = lft_w + IW'(1);
    assign cnt_w     = IW'(cnt_reg);
    assign has_left  = lft_w < cnt_w;
    assign has_right = rgt_w < cnt_w;

    // The right child wins a tie between the two children.
    assign pick_left = lkey_reg > mem_rdata;
    assign max_key   = pick_left ? lkey_reg : mem_rdata;
    assign max_idx   = pick_left ? AW'(lft_w) : AW'(rgt_w);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    // Every sift keeps the moving key in key_reg and writes each displaced
    // entry exactly once, so a write is never followed by a read of the same
    // entry within one request. A new request issues its first read no earlier
    // than the edge after the last write, which the memory already holds.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        tgt_next   = tgt_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        lkey_next  = lkey_reg;
        kout_next  = kout_reg;
        stat_next  = stat_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = key_reg;
        mem_re     = 1'b0;
        mem_raddr  = par_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kout_next  = '0;
                    stat_next  = ST_OK;
                    state_next = S_DONE;
                    unique case (opcode_t'(req.opcode))
                        OP_PUSH:
                        begin
                            if (cnt_reg >= CW'(DEPTH))
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                key_next   = KEY_W'(req.key_in);
                                idx_next   = AW'(cnt_reg);
                                cnt_next   = cnt_reg + CW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                tgt_next   = '0;
                                state_next = S_TAKE;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else if (XW'(req.slot) >= XW'(cnt_reg))
                            begin
                                stat_next = ST_BAD_SLOT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(req.slot);
                                tgt_next   = AW'(req.slot);
                                state_next = S_TAKE;
                            end
                        end
                        default:
                        begin
                            stat_next = ST_OK;
                        end
                    endcase
                end
            end

            S_TAKE:
            begin
                kout_next  = mem_rdata;
                cnt_next   = cnt_reg - CW'(1);
                mem_re     = 1'b1;
                mem_raddr  = AW'(cnt_reg - CW'(1));
                state_next = S_LAST;
            end

            S_LAST:
            begin
                key_next = mem_rdata;
                idx_next = tgt_reg;
                if (IW'(tgt_reg) == cnt_w)
                begin
                    state_next = S_DONE;
                end
                else if (tgt_reg == '0)
                begin
                    state_next = S_DN_L;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = tgt_par;
                    state_next = S_RM_CMP;
                end
            end

            S_RM_CMP:
            begin
                if (key_reg > mem_rdata)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    idx_next   = par_idx;
                    state_next = S_UP_RD;
                end
                else if (key_reg < mem_rdata)
                begin
                    state_next = S_DN_L;
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = par_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (key_reg > mem_rdata)
                begin
                    mem_wdata  = mem_rdata;
                    idx_next   = par_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DN_L:
            begin
                if (!has_left)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(lft_w);
                    state_next = S_DN_R;
                end
            end

            S_DN_R:
            begin
                lkey_next = mem_rdata;
                if (has_right)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(rgt_w);
                    state_next = S_DN_CMP;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (mem_rdata > key_reg)
                    begin
                        mem_wdata  = mem_rdata;
                        idx_next   = AW'(lft_w);
                        state_next = S_DN_L;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (max_key > key_reg)
                begin
                    mem_wdata  = max_key;
                    idx_next   = max_idx;
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_key_next    = rsp_key_reg;
        rsp_status_next = rsp_status_reg;
        rsp_occ_next    = rsp_occ_reg;
        if (rsp_load)
        begin
            rsp_valid_next  = 1'b1;
            rsp_key_next    = KEYIO_W'(kout_reg);
            rsp_status_next = stat_reg;
            rsp_occ_next    = OCC_W'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        tgt_reg        <= tgt_next;
        key_reg        <= key_next;
        lkey_reg       <= lkey_next;
        kout_reg       <= kout_next;
        stat_reg       <= stat_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_status_reg <= rsp_status_next;
        rsp_occ_reg    <= rsp_occ_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.key_out   = rsp_key_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.occupancy = rsp_occ_reg;

    // The heap store is only touched while a request is being worked on.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("heap store written while idle");

    // An accepted request always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    // A dropped push is reported only when the heap is really full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (stat_reg == ST_FULL)) |-> (cnt_reg == CW'(DEPTH)))
        else $error("full status with free entries");

endmodule

`default_nettype wire
